### sv/history_score_table_gravity_unit_macros.svh
// assertion macros for the history score table
`ifndef HISTORY_SCORE_TABLE_GRAVITY_UNIT_MACROS_SVH
`define HISTORY_SCORE_TABLE_GRAVITY_UNIT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, sampled on clk_i, off during reset
`define HST_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("history score table check failed");
// next-cycle implication, sampled on clk_i, off during reset
`define HST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("history score table check failed");
`else
`define HST_ASSERT_NOW(label, ante, cons)
`define HST_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### sv/hst_pkg.sv
// ----------------------------------------------------------------------------
// hst_pkg
// Widths, command codes and shared types of the history score table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hst_pkg;

  localparam int SCORE_CAP = 8192;
  localparam int CAP_LOG2  = $clog2(SCORE_CAP);
  localparam int SQUARES   = 64;
  localparam int SQ_W      = $clog2(SQUARES);
  localparam int ADDR_W    = 1 + 2 * SQ_W;
  localparam int DEPTH     = 2 * SQUARES * SQUARES;

  localparam int CMD_W     = 2;
  localparam int DEPTH_W   = 7;
  localparam int SQR_W     = 2 * DEPTH_W;
  localparam int SCORE_W   = 15;

  // bonus holds values up to the cap itself
  localparam int B_W       = CAP_LOG2 + 1;
  localparam int HI_W      = SCORE_W + 1;
  localparam int PROD_W    = HI_W + B_W;
  localparam int DAMP_W    = PROD_W - CAP_LOG2;
  localparam int NXT_W     = DAMP_W + 2;
  localparam int MCNT_W    = $clog2(B_W + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_READ     = 2'd0,
    CMD_REWARD   = 2'd1,
    CMD_PENALIZE = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_e;

  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] prod;
  } mul_res_t;

endpackage

`default_nettype wire

### sv/hst_serial_mul.sv
// ----------------------------------------------------------------------------
// hst_serial_mul
// Bit-serial signed by unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hst_serial_mul (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic signed [hst_pkg::SCORE_W-1:0] mcand_i,
  input  wire logic        [hst_pkg::B_W-1:0]     mplier_i,
  output hst_pkg::mul_res_t                       res_o
);

  logic signed [hst_pkg::SCORE_W-1:0] mcand_q;
  logic signed [hst_pkg::HI_W-1:0]    hi_q, hi_d;
  logic        [hst_pkg::B_W-1:0]     lo_q, lo_d;
  logic        [hst_pkg::MCNT_W-1:0]  cnt_q, cnt_d;
  logic                               done_q, done_d;
  logic signed [hst_pkg::HI_W-1:0]    sum;

  // partial product stays below the multiplicand in magnitude, so no overflow
  always_comb begin
    sum    = hi_q + (lo_q[0] ? hst_pkg::HI_W'(mcand_q) : '0);
    hi_d   = hi_q;
    lo_d   = lo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      hi_d  = '0;
      lo_d  = mplier_i;
      cnt_d = hst_pkg::MCNT_W'(hst_pkg::B_W);
    end else if (cnt_q != '0) begin
      hi_d   = sum >>> 1;
      lo_d   = {sum[0], lo_q[hst_pkg::B_W-1:1]};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == hst_pkg::MCNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= mcand_i;
    end
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  assign res_o.done = done_q;
  assign res_o.prod = {hi_q, lo_q};

endmodule

`default_nettype wire

### sv/history_score_table_gravity_unit.sv
// ----------------------------------------------------------------------------
// history_score_table_gravity_unit
// History score table with gravity update, indexed by side and move squares.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low; its one result
// appears on score_o for a single cycle with score_valid_o high and must be
// taken then, since the receiver cannot stall the block. A read returns its
// score after the states ST_RD and ST_CHK, which cover the registered table read.
// A reward or penalize goes through the read, then the bit-serial multiply of
// score by bonus at one bonus bit per cycle, then the write-back.
// A clear sweeps the 8192-entry table one entry per cycle and then reports
// zero. After reset the same clearing pass runs with busy_o high and no
// result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "history_score_table_gravity_unit_macros.svh"

module history_score_table_gravity_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  output logic                                    busy_o,
  input  wire logic [hst_pkg::CMD_W-1:0]          command_i,
  input  wire logic                               side_i,
  input  wire logic [hst_pkg::SQ_W-1:0]           from_square_i,
  input  wire logic [hst_pkg::SQ_W-1:0]           to_square_i,
  input  wire logic [hst_pkg::DEPTH_W-1:0]        depth_i,
  output logic                                    score_valid_o,
  output logic signed [hst_pkg::SCORE_W-1:0]      score_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RD   = 6'b000010,
    ST_CHK  = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_UPD  = 6'b010000,
    ST_CLR  = 6'b100000
  } state_e;

  state_e                              state_q, state_d;
  hst_pkg::cmd_e                       cmd_q;
  logic [hst_pkg::ADDR_W-1:0]          addr_q;
  logic [hst_pkg::B_W-1:0]             b_q;
  logic [hst_pkg::ADDR_W-1:0]          clr_cnt_q, clr_cnt_d;
  logic                                report_q, report_d;
  logic                                valid_q, valid_d;
  logic signed [hst_pkg::SCORE_W-1:0]  score_q, score_d;

  logic signed [hst_pkg::SCORE_W-1:0]  mem [hst_pkg::DEPTH];
  logic signed [hst_pkg::SCORE_W-1:0]  rdata_q;
  logic                                we;
  logic [hst_pkg::ADDR_W-1:0]          waddr;
  logic signed [hst_pkg::SCORE_W-1:0]  wdata;

  logic                                accept;
  logic [hst_pkg::SQR_W-1:0]           sqr;
  logic [hst_pkg::B_W-1:0]             b_d;
  logic                                mul_start;
  hst_pkg::mul_res_t                   mul_res;

  logic signed [hst_pkg::PROD_W-1:0]   bias;
  logic signed [hst_pkg::PROD_W-1:0]   damp_sum;
  logic signed [hst_pkg::DAMP_W-1:0]   damp;
  logic signed [hst_pkg::NXT_W-1:0]    b_ext;
  logic signed [hst_pkg::NXT_W-1:0]    nxt;
  logic signed [hst_pkg::SCORE_W-1:0]  nxt_sat;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  // bonus is depth squared, capped
  assign sqr = {{hst_pkg::DEPTH_W{1'b0}}, depth_i} * {{hst_pkg::DEPTH_W{1'b0}}, depth_i};
  assign b_d = (32'(sqr) > 32'(hst_pkg::SCORE_CAP)) ? hst_pkg::B_W'(hst_pkg::SCORE_CAP)
                                                    : hst_pkg::B_W'(sqr);

  assign mul_start = (state_q == ST_CHK) && (cmd_q != hst_pkg::CMD_READ);

  hst_serial_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (rdata_q),
    .mplier_i (b_q),
    .res_o    (mul_res)
  );

  // s*b/cap truncated toward zero: bias negative products before the shift
  always_comb begin
    bias     = mul_res.prod[hst_pkg::PROD_W-1] ? hst_pkg::PROD_W'(hst_pkg::SCORE_CAP - 1) : '0;
    damp_sum = mul_res.prod + bias;
    damp     = hst_pkg::DAMP_W'(damp_sum >>> hst_pkg::CAP_LOG2);
    b_ext    = hst_pkg::NXT_W'($signed({1'b0, b_q}));
    nxt      = hst_pkg::NXT_W'(rdata_q)
             + ((cmd_q == hst_pkg::CMD_REWARD) ? b_ext : -b_ext)
             - hst_pkg::NXT_W'(damp);
    if (nxt > hst_pkg::NXT_W'(hst_pkg::SCORE_CAP)) begin
      nxt_sat = hst_pkg::SCORE_W'(hst_pkg::SCORE_CAP);
    end else if (nxt < -hst_pkg::NXT_W'(hst_pkg::SCORE_CAP)) begin
      nxt_sat = -hst_pkg::SCORE_W'(hst_pkg::SCORE_CAP);
    end else begin
      nxt_sat = hst_pkg::SCORE_W'(nxt);
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    report_d  = report_q;
    valid_d   = 1'b0;
    score_d   = score_q;
    we        = 1'b0;
    waddr     = addr_q;
    wdata     = nxt_sat;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (hst_pkg::cmd_e'(command_i) == hst_pkg::CMD_CLEAR) begin
            state_d   = ST_CLR;
            clr_cnt_d = '0;
            report_d  = 1'b1;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (cmd_q == hst_pkg::CMD_READ) begin
          state_d = ST_IDLE;
          valid_d = 1'b1;
          score_d = rdata_q;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_res.done) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        we      = 1'b1;
        state_d = ST_IDLE;
        valid_d = 1'b1;
        score_d = nxt_sat;
      end
      ST_CLR: begin
        we        = 1'b1;
        waddr     = clr_cnt_q;
        wdata     = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == hst_pkg::ADDR_W'(hst_pkg::DEPTH - 1)) begin
          state_d = ST_IDLE;
          valid_d = report_q;
          score_d = '0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // a clearing pass runs after reset, without a result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLR;
      clr_cnt_q <= '0;
      report_q  <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      report_q  <= report_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    score_q <= score_d;
    if (accept) begin
      cmd_q  <= hst_pkg::cmd_e'(command_i);
      addr_q <= {side_i, from_square_i, to_square_i};
      b_q    <= b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[addr_q];
  end

  assign score_valid_o = valid_q;
  assign score_o       = score_q;

  `HST_ASSERT_NEXT(a_strobe_single, score_valid_o, !score_valid_o)
  `HST_ASSERT_NOW(a_clear_zero, score_valid_o && (cmd_q == hst_pkg::CMD_CLEAR), score_o == '0)
  `HST_ASSERT_NOW(a_mul_done_in_mul, mul_res.done, state_q == ST_MUL)
  `HST_ASSERT_NEXT(a_accept_busy, accept, busy_o)

endmodule

`default_nettype wire

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the history score table with gravity update. Items
// go in through the start/busy handshake with random gaps or none, and every
// score is checked against a local copy of the table updated the same way.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import hst_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_CLEARS  = 20;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start_i;
  logic                      busy_o;
  logic [CMD_W-1:0]          command_i;
  logic                      side_i;
  logic [SQ_W-1:0]           from_square_i;
  logic [SQ_W-1:0]           to_square_i;
  logic [DEPTH_W-1:0]        depth_i;
  logic                      score_valid_o;
  logic signed [SCORE_W-1:0] score_o;

  history_score_table_gravity_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .command_i     (command_i),
    .side_i        (side_i),
    .from_square_i (from_square_i),
    .to_square_i   (to_square_i),
    .depth_i       (depth_i),
    .score_valid_o (score_valid_o),
    .score_o       (score_o)
  );

  // local copy of the table and the scores still owed by the block
  int                        score_mem [DEPTH];
  logic signed [SCORE_W-1:0] pending_scores [$];
  int                        error_count;
  int                        cycle_count;
  int                        clears_left;
  bit                        idle_off;

  // hot entries so repeated updates drive scores toward the bounds
  bit                        hot_side [8];
  logic [SQ_W-1:0]           hot_from [8];
  logic [SQ_W-1:0]           hot_to [8];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic signed [SCORE_W-1:0] gravity_predict(
      cmd_e cmd, bit side, logic [SQ_W-1:0] from_sq, logic [SQ_W-1:0] to_sq,
      logic [DEPTH_W-1:0] depth);
    int     idx;
    longint bonus;
    longint cur;
    longint damp;
    longint nxt;
    bonus = longint'(depth) * longint'(depth);
    if (bonus > SCORE_CAP) bonus = SCORE_CAP;
    if (cmd == CMD_CLEAR) begin
      foreach (score_mem[i]) score_mem[i] = 0;
      return '0;
    end
    idx = (int'(side) * SQUARES + int'(from_sq)) * SQUARES + int'(to_sq);
    if (cmd != CMD_READ) begin
      cur  = score_mem[idx];
      // longint division truncates toward zero
      damp = (cur * bonus) / SCORE_CAP;
      nxt  = (cmd == CMD_REWARD) ? cur + bonus - damp : cur - bonus - damp;
      if (nxt > SCORE_CAP) nxt = SCORE_CAP;
      if (nxt < -SCORE_CAP) nxt = -SCORE_CAP;
      score_mem[idx] = int'(nxt);
    end
    return SCORE_W'(score_mem[idx]);
  endfunction

  task automatic send_item(cmd_e cmd, bit side, logic [SQ_W-1:0] from_sq,
                           logic [SQ_W-1:0] to_sq, logic [DEPTH_W-1:0] depth);
    int gap;
    gap = idle_off ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i       <= 1'b1;
    command_i     <= cmd;
    side_i        <= side;
    from_square_i <= from_sq;
    to_square_i   <= to_sq;
    depth_i       <= depth;
    do @(posedge clk_i); while (busy_o);
    pending_scores.push_back(gravity_predict(cmd, side, from_sq, to_sq, depth));
  endtask

  function automatic cmd_e pick_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return CMD_READ;
    if (r < 59) return CMD_REWARD;
    if (r < 98) return CMD_PENALIZE;
    if (clears_left > 0) begin
      clears_left--;
      return CMD_CLEAR;
    end
    return CMD_READ;
  endfunction

  function automatic logic [DEPTH_W-1:0] pick_depth();
    // mix of shallow depths and depths past the cap
    if ($urandom_range(0, 2) == 0) return DEPTH_W'($urandom_range(0, 12));
    return DEPTH_W'($urandom_range(0, 127));
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && score_valid_o) begin
      if (pending_scores.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected score %0d with no item pending", score_o);
      end else if (score_o !== pending_scores[0]) begin
        error_count++;
        if (error_count <= 10)
          $display("score mismatch: expected %0d got %0d", pending_scores[0], score_o);
        void'(pending_scores.pop_front());
      end else begin
        void'(pending_scores.pop_front());
      end
    end
  end

  task automatic test_saturation();
    idle_off = 1'b0;
    send_item(CMD_READ,     1'b0, 6'd0,  6'd0,  7'd0);
    send_item(CMD_REWARD,   1'b1, 6'd63, 6'd63, 7'd127);
    send_item(CMD_READ,     1'b1, 6'd63, 6'd63, 7'd0);
    send_item(CMD_REWARD,   1'b1, 6'd63, 6'd63, 7'd90);
    send_item(CMD_REWARD,   1'b1, 6'd63, 6'd63, 7'd91);
    send_item(CMD_PENALIZE, 1'b1, 6'd63, 6'd63, 7'd127);
    send_item(CMD_PENALIZE, 1'b1, 6'd63, 6'd63, 7'd127);
    send_item(CMD_READ,     1'b1, 6'd63, 6'd63, 7'd127);
  endtask

  task automatic test_small_updates();
    idle_off = 1'b1;
    send_item(CMD_REWARD,   1'b0, 6'd5,  6'd9,  7'd0);
    send_item(CMD_REWARD,   1'b0, 6'd5,  6'd9,  7'd1);
    send_item(CMD_PENALIZE, 1'b0, 6'd63, 6'd0,  7'd13);
    send_item(CMD_REWARD,   1'b0, 6'd10, 6'd10, 7'd64);
    send_item(CMD_PENALIZE, 1'b0, 6'd10, 6'd10, 7'd64);
    // negative damping truncates toward zero
    send_item(CMD_PENALIZE, 1'b0, 6'd10, 6'd10, 7'd3);
    send_item(CMD_REWARD,   1'b0, 6'd10, 6'd10, 7'd3);
    send_item(CMD_READ,     1'b0, 6'd42, 6'd21, 7'd85);
  endtask

  task automatic test_clear();
    idle_off = 1'b0;
    send_item(CMD_CLEAR,    1'b1, 6'd63, 6'd63, 7'd127);
    send_item(CMD_READ,     1'b1, 6'd63, 6'd63, 7'd0);
    send_item(CMD_READ,     1'b0, 6'd10, 6'd10, 7'd0);
    send_item(CMD_PENALIZE, 1'b0, 6'd10, 6'd10, 7'd90);
    send_item(CMD_CLEAR,    1'b0, 6'd0,  6'd0,  7'd0);
    send_item(CMD_READ,     1'b0, 6'd10, 6'd10, 7'd0);
  endtask

  task automatic test_random_hot(int count);
    int k;
    foreach (hot_side[i]) begin
      hot_side[i] = $urandom_range(0, 1);
      hot_from[i] = SQ_W'($urandom_range(0, 63));
      hot_to[i]   = SQ_W'($urandom_range(0, 63));
    end
    for (int i = 0; i < count; i++) begin
      idle_off = ((i / 50) % 3 == 2);
      k = $urandom_range(0, 7);
      send_item(pick_command(), hot_side[k], hot_from[k], hot_to[k], pick_depth());
    end
  endtask

  task automatic test_random_wide(int count);
    for (int i = 0; i < count; i++) begin
      idle_off = ((i / 40) % 4 == 1);
      send_item(pick_command(), 1'($urandom_range(0, 1)), SQ_W'($urandom_range(0, 63)),
                SQ_W'($urandom_range(0, 63)), DEPTH_W'($urandom_range(0, 127)));
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    command_i     = CMD_READ;
    side_i        = 1'b0;
    from_square_i = '0;
    to_square_i   = '0;
    depth_i       = '0;
    error_count   = 0;
    cycle_count   = 0;
    clears_left   = MAX_CLEARS;
    idle_off      = 1'b0;
    foreach (score_mem[i]) score_mem[i] = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    test_saturation();
    test_small_updates();
    test_clear();
    test_random_hot(700);
    test_random_wide(400);

    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (error_count == 0 && pending_scores.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/hst_pkg.sv
sv/hst_serial_mul.sv
sv/history_score_table_gravity_unit.sv
test/testbench.sv
